// ----- rtl/ols_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ordered list store.
// No dependencies; imported by ols_cell, ols_ctrl and ordered_list_store_top.
package ols_pkg;

    localparam int OLS_CAPACITY = 256;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 9;
    localparam int DATA_W       = 32;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_GET    = 3'd2,
        K_LOCATE = 3'd3,
        K_PRED   = 3'd4,
        K_SUCC   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_CLEAR  = 3'd3,
        CELL_SCAN   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        kind_t                     kind;
        logic [POS_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ----- rtl/ols_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one word and one stage of the search result path.
// Depends on ols_pkg.
module ols_cell
    import ols_pkg::*;
#(
    parameter int CAPACITY = OLS_CAPACITY,
    parameter int INDEX    = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] left_word,
    input  logic signed [DATA_W-1:0] right_word,
    input  logic                     right_found,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic [CNT_W-1:0]         right_pos,
    output logic signed [DATA_W-1:0] word,
    output logic                     found,
    output logic signed [DATA_W-1:0] res_value,
    output logic [CNT_W-1:0]         res_pos
);

    localparam int IW = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [IW-1:0] MY_POS = IW'(INDEX + 1);
    localparam bit HAS_LEFT = (INDEX != 0);

    logic signed [DATA_W-1:0] word_reg, word_next;
    logic                     found_reg, found_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;

    logic [IW-1:0]            n_ext;
    logic [IW-1:0]            p_ext;
    logic                     in_list;
    logic                     equal;
    logic                     hit;
    logic signed [DATA_W-1:0] hit_value;

    always_comb
    begin
        n_ext     = IW'(count);
        p_ext     = IW'(ctrl.pos);
        in_list   = MY_IDX < n_ext;
        equal     = word_reg == ctrl.value;
        hit       = 1'b0;
        hit_value = word_reg;
        case (ctrl.kind)
            K_DELETE, K_GET:
                hit = in_list && (MY_POS == p_ext);
            K_LOCATE:
                hit = in_list && equal;
            K_PRED:
            begin
                hit       = in_list && equal && HAS_LEFT;
                hit_value = left_word;
            end
            K_SUCC:
            begin
                hit       = equal && (MY_POS < n_ext);
                hit_value = right_word;
            end
            default:
                hit = 1'b0;
        endcase

        word_next  = word_reg;
        found_next = found_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        unique case (ctrl.op)
            CELL_HOLD:
                word_next = word_reg;
            CELL_INSERT:
            begin
                if (MY_POS == p_ext)
                    word_next = ctrl.value;
                else if (MY_POS > p_ext)
                    word_next = left_word;
            end
            CELL_DELETE:
            begin
                if (MY_POS >= p_ext)
                    word_next = right_word;
            end
            CELL_CLEAR:
                found_next = 1'b0;
            CELL_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    value_next = hit_value;
                    pos_next   = CNT_W'(INDEX + 1);
                end
                else
                begin
                    found_next = right_found;
                    value_next = right_value;
                    pos_next   = right_pos;
                end
            end
            default:
                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        found_reg <= found_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign word      = word_reg;
    assign found     = found_reg;
    assign res_value = value_reg;
    assign res_pos   = pos_reg;

endmodule

// ----- rtl/ols_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the ordered list store: handshakes, length count, cell commands, result register.
// Depends on ols_pkg.
module ols_ctrl
    import ols_pkg::*;
#(
    parameter int CAPACITY = OLS_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] result_value,
    output logic [POS_W-1:0]         found_position,
    output logic [POS_W-1:0]         list_length,
    output logic                     is_empty,
    output cell_ctrl_t               cell_ctrl,
    output logic [CNT_W-1:0]         count,
    input  logic                     res_found,
    input  logic signed [DATA_W-1:0] res_value,
    input  logic [CNT_W-1:0]         res_pos
);

    localparam int IW = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EW = IW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         scan_cnt_reg, scan_cnt_next;
    kind_t                    q_kind_reg, q_kind_next;
    logic [POS_W-1:0]         q_pos_reg, q_pos_next;
    logic signed [DATA_W-1:0] q_value_reg, q_value_next;
    status_t                  pend_status_reg, pend_status_next;
    logic signed [DATA_W-1:0] pend_value_reg, pend_value_next;
    logic [POS_W-1:0]         pend_fpos_reg, pend_fpos_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] result_value_reg, result_value_next;
    logic [POS_W-1:0]         found_position_reg, found_position_next;
    logic [POS_W-1:0]         list_length_reg, list_length_next;
    logic                     is_empty_reg, is_empty_next;

    logic [EW-1:0]            p_ext;
    logic [EW-1:0]            n_ext;
    logic                     pos_zero;

    always_comb
    begin
        p_ext    = EW'(q_pos_reg);
        n_ext    = EW'(count_reg);
        pos_zero = q_pos_reg == '0;

        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.kind  = q_kind_reg;
        cell_ctrl.pos   = q_pos_reg;
        cell_ctrl.value = q_value_reg;

        state_next          = state_reg;
        count_next          = count_reg;
        scan_cnt_next       = scan_cnt_reg;
        q_kind_next         = q_kind_reg;
        q_pos_next          = q_pos_reg;
        q_value_next        = q_value_reg;
        pend_status_next    = pend_status_reg;
        pend_value_next     = pend_value_reg;
        pend_fpos_next      = pend_fpos_reg;
        out_valid_next      = out_valid_reg;
        status_next         = status_reg;
        result_value_next   = result_value_reg;
        found_position_next = found_position_reg;
        list_length_next    = list_length_reg;
        is_empty_next       = is_empty_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    q_kind_next  = kind_t'(kind);
                    q_pos_next   = position;
                    q_value_next = value;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                pend_status_next = ST_OK;
                pend_value_next  = '0;
                pend_fpos_next   = '0;
                state_next       = S_OUT;
                case (q_kind_reg)
                    K_INSERT:
                    begin
                        if (pos_zero || (p_ext - EW'(1) > n_ext))
                            pend_status_next = ST_BADPOS;
                        else if (count_reg == CNT_W'(CAPACITY))
                            pend_status_next = ST_FULL;
                        else
                        begin
                            cell_ctrl.op = CELL_INSERT;
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end
                    K_DELETE, K_GET:
                    begin
                        if (pos_zero || (p_ext > n_ext))
                            pend_status_next = ST_BADPOS;
                        else
                        begin
                            cell_ctrl.op  = CELL_CLEAR;
                            scan_cnt_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    K_LOCATE, K_PRED, K_SUCC:
                    begin
                        cell_ctrl.op  = CELL_CLEAR;
                        scan_cnt_next = '0;
                        state_next    = S_SCAN;
                    end
                    default:
                        pend_status_next = ST_OK;
                endcase
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == count_reg)
                begin
                    state_next = S_OUT;
                    if (res_found)
                    begin
                        pend_status_next = ST_OK;
                        if (q_kind_reg == K_LOCATE)
                            pend_fpos_next = POS_W'(res_pos);
                        else
                            pend_value_next = res_value;
                    end
                    else
                        pend_status_next = ST_NOTFOUND;
                    if (q_kind_reg == K_DELETE)
                    begin
                        cell_ctrl.op = CELL_DELETE;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    cell_ctrl.op  = CELL_SCAN;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = pend_status_reg;
                    result_value_next   = pend_value_reg;
                    found_position_next = pend_fpos_reg;
                    list_length_next    = POS_W'(count_reg);
                    is_empty_next       = count_reg == '0;
                    state_next          = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            count_reg          <= '0;
            scan_cnt_reg       <= '0;
            q_kind_reg         <= K_INSERT;
            q_pos_reg          <= '0;
            q_value_reg        <= '0;
            pend_status_reg    <= ST_OK;
            pend_value_reg     <= '0;
            pend_fpos_reg      <= '0;
            out_valid_reg      <= 1'b0;
            status_reg         <= ST_OK;
            result_value_reg   <= '0;
            found_position_reg <= '0;
            list_length_reg    <= '0;
            is_empty_reg       <= 1'b1;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            scan_cnt_reg       <= scan_cnt_next;
            q_kind_reg         <= q_kind_next;
            q_pos_reg          <= q_pos_next;
            q_value_reg        <= q_value_next;
            pend_status_reg    <= pend_status_next;
            pend_value_reg     <= pend_value_next;
            pend_fpos_reg      <= pend_fpos_next;
            out_valid_reg      <= out_valid_next;
            status_reg         <= status_next;
            result_value_reg   <= result_value_next;
            found_position_reg <= found_position_next;
            list_length_reg    <= list_length_next;
            is_empty_reg       <= is_empty_next;
        end
    end

    assign in_stall       = state_reg != S_IDLE;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_value   = result_value_reg;
    assign found_position = found_position_reg;
    assign list_length    = list_length_reg;
    assign is_empty       = is_empty_reg;
    assign count          = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_cnt_reg <= count_reg)
        else $error("scan ran past the list end");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == S_START || $past(state_reg) == S_SCAN))
        else $error("list length changed outside an update");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised without a finished transaction");

endmodule

// ----- rtl/ordered_list_store_top.sv -----
`timescale 1ns / 1ps
// Ordered list store: a chain of CAPACITY word cells under one sequencer.
// Insert, unused kinds, and any request with a bad position pass from idle through the start
// state to the output state, which registers the result while out_stall does not hold it.
// Get, delete, locate, predecessor and successor walk the result path of the cell chain one
// cell per cycle in the scan state first. A new request is accepted only in the idle state.
// Reset (rst_n low, asynchronous) empties the list; stored words are not cleared.
module ordered_list_store_top
    import ols_pkg::*;
#(
    parameter int CAPACITY = OLS_CAPACITY
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] result_value,
    output logic [POS_W-1:0]         found_position,
    output logic [POS_W-1:0]         list_length,
    output logic                     is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctrl_t               cell_ctrl;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] word_w  [CAPACITY+2];
    logic                     found_w [CAPACITY+1];
    logic signed [DATA_W-1:0] value_w [CAPACITY+1];
    logic [CNT_W-1:0]         pos_w   [CAPACITY+1];

    assign word_w[0]           = '0;
    assign word_w[CAPACITY+1]  = '0;
    assign found_w[CAPACITY]   = 1'b0;
    assign value_w[CAPACITY]   = '0;
    assign pos_w[CAPACITY]     = '0;

    ols_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_value   (result_value),
        .found_position (found_position),
        .list_length    (list_length),
        .is_empty       (is_empty),
        .cell_ctrl      (cell_ctrl),
        .count          (count),
        .res_found      (found_w[0]),
        .res_value      (value_w[0]),
        .res_pos        (pos_w[0])
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ols_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .count       (count),
            .left_word   (word_w[i]),
            .right_word  (word_w[i+2]),
            .right_found (found_w[i+1]),
            .right_value (value_w[i+1]),
            .right_pos   (pos_w[i+1]),
            .word        (word_w[i+1]),
            .found       (found_w[i]),
            .res_value   (value_w[i]),
            .res_pos     (pos_w[i])
        );
    end

endmodule

// ----- dv/ordered_list_store_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_store_top: directed table, then random list traffic.
// Depends on ols_pkg and ordered_list_store_top; keeps its own model of the list contents.
module ordered_list_store_top_tb;
    import ols_pkg::*;

    localparam int CAPACITY       = OLS_CAPACITY;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SMALL_ITEMS    = 400;
    localparam int STEADY_ITEMS   = 80;

    localparam logic [KIND_W-1:0] K_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE7 = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]               st;
        logic signed [DATA_W-1:0] rval;
        logic [POS_W-1:0]         fpos;
        logic [POS_W-1:0]         len;
        logic                     empty;
    } list_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]        op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic                     typed;
        logic [1:0]               st;
        logic signed [DATA_W-1:0] rval;
        logic [POS_W-1:0]         fpos;
        logic [POS_W-1:0]         len;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 26;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{K_GET,    9'd1,   32'sd0,   1'b1, ST_BADPOS,   32'sd0,   9'd0, 9'd0},
        '{K_LOCATE, 9'd0,   32'sd5,   1'b1, ST_NOTFOUND, 32'sd0,   9'd0, 9'd0},
        '{K_SUCC,   9'd0,   32'sd0,   1'b1, ST_NOTFOUND, 32'sd0,   9'd0, 9'd0},
        '{K_PRED,   9'd0,   32'sd0,   1'b1, ST_NOTFOUND, 32'sd0,   9'd0, 9'd0},
        '{K_DELETE, 9'd1,   32'sd0,   1'b1, ST_BADPOS,   32'sd0,   9'd0, 9'd0},
        '{K_INSERT, 9'd0,   32'sd7,   1'b1, ST_BADPOS,   32'sd0,   9'd0, 9'd0},
        '{K_INSERT, 9'd2,   32'sd7,   1'b1, ST_BADPOS,   32'sd0,   9'd0, 9'd0},
        '{K_INSERT, 9'd1,   WORD_MIN, 1'b1, ST_OK,       32'sd0,   9'd0, 9'd1},
        '{K_INSERT, 9'd2,   WORD_MAX, 1'b1, ST_OK,       32'sd0,   9'd0, 9'd2},
        '{K_GET,    9'd1,   32'sd0,   1'b1, ST_OK,       WORD_MIN, 9'd0, 9'd2},
        '{K_GET,    9'd2,   32'sd0,   1'b1, ST_OK,       WORD_MAX, 9'd0, 9'd2},
        '{K_GET,    9'd3,   32'sd0,   1'b1, ST_BADPOS,   32'sd0,   9'd0, 9'd2},
        '{K_INSERT, 9'd511, 32'sd1,   1'b1, ST_BADPOS,   32'sd0,   9'd0, 9'd2},
        '{K_LOCATE, 9'd0,   WORD_MAX, 1'b1, ST_OK,       32'sd0,   9'd2, 9'd2},
        '{K_PRED,   9'd0,   WORD_MAX, 1'b1, ST_OK,       WORD_MIN, 9'd0, 9'd2},
        '{K_PRED,   9'd0,   WORD_MIN, 1'b1, ST_NOTFOUND, 32'sd0,   9'd0, 9'd2},
        '{K_SUCC,   9'd0,   WORD_MIN, 1'b1, ST_OK,       WORD_MAX, 9'd0, 9'd2},
        '{K_SUCC,   9'd0,   WORD_MAX, 1'b1, ST_NOTFOUND, 32'sd0,   9'd0, 9'd2},
        '{K_SPARE6, 9'd511, -32'sd1,  1'b1, ST_OK,       32'sd0,   9'd0, 9'd2},
        '{K_SPARE7, 9'd0,   32'sd0,   1'b1, ST_OK,       32'sd0,   9'd0, 9'd2},
        '{K_INSERT, 9'd2,   -32'sd1,  1'b0, ST_OK,       32'sd0,   9'd0, 9'd0},
        '{K_INSERT, 9'd4,   -32'sd1,  1'b0, ST_OK,       32'sd0,   9'd0, 9'd0},
        '{K_LOCATE, 9'd0,   -32'sd1,  1'b0, ST_OK,       32'sd0,   9'd0, 9'd0},
        '{K_PRED,   9'd0,   -32'sd1,  1'b0, ST_OK,       32'sd0,   9'd0, 9'd0},
        '{K_DELETE, 9'd1,   32'sd0,   1'b1, ST_OK,       WORD_MIN, 9'd0, 9'd3},
        '{K_DELETE, 9'd3,   32'sd0,   1'b0, ST_OK,       32'sd0,   9'd0, 9'd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] result_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
    logic                     is_empty;

    logic signed [DATA_W-1:0] list_words [CAPACITY];
    int                       list_count = 0;
    list_result_t             pending_results [$];
    int                       mismatch_count = 0;
    int                       results_taken = 0;
    int                       idle_cycles = 0;
    bit                       steady_phase = 0;
    bit                       holdoff_done = 0;

    ordered_list_store_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_value   (result_value),
        .found_position (found_position),
        .list_length    (list_length),
        .is_empty       (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           n;
        int           p;
        int           k;
        r    = '0;
        r.st = ST_OK;
        n    = list_count;
        p    = int'(pos);
        case (op)
            K_INSERT:
            begin
                if (p < 1 || p > n + 1)
                    r.st = ST_BADPOS;
                else if (n >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    for (k = n; k >= p; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[p - 1] = val;
                    n++;
                end
            end
            K_DELETE:
            begin
                if (p < 1 || p > n)
                    r.st = ST_BADPOS;
                else
                begin
                    r.rval = list_words[p - 1];
                    for (k = p; k < n; k++)
                        list_words[k - 1] = list_words[k];
                    n--;
                end
            end
            K_GET:
            begin
                if (p < 1 || p > n)
                    r.st = ST_BADPOS;
                else
                    r.rval = list_words[p - 1];
            end
            K_LOCATE:
            begin
                r.st = ST_NOTFOUND;
                for (k = 0; k < n; k++)
                    if (r.st == ST_NOTFOUND && list_words[k] == val)
                    begin
                        r.fpos = POS_W'(k + 1);
                        r.st   = ST_OK;
                    end
            end
            K_PRED:
            begin
                r.st = ST_NOTFOUND;
                for (k = 1; k < n; k++)
                    if (r.st == ST_NOTFOUND && list_words[k] == val)
                    begin
                        r.rval = list_words[k - 1];
                        r.st   = ST_OK;
                    end
            end
            K_SUCC:
            begin
                r.st = ST_NOTFOUND;
                for (k = 0; k + 1 < n; k++)
                    if (r.st == ST_NOTFOUND && list_words[k] == val)
                    begin
                        r.rval = list_words[k + 1];
                        r.st   = ST_OK;
                    end
            end
            default:
            begin
            end
        endcase
        list_count = n;
        r.len      = POS_W'(n);
        r.empty    = (n == 0);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return (list_count > 0) ? list_words[$urandom_range(0, list_count - 1)]
                                                : $urandom;
            4:          return WORD_MIN;
            5:          return WORD_MAX;
            6:          return 32'sd0;
            7:          return -32'sd1;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input int span);
        if (span > 0 && $urandom_range(0, 9) != 0)
            return POS_W'($urandom_range(1, span));
        return POS_W'($urandom_range(0, 511));
    endfunction

    // Enter at a falling edge, leave at the falling edge after acceptance.
    task automatic send_op(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val, input bit typed,
                           input list_result_t typed_res);
        list_result_t predicted;
        if (!steady_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        kind     = op;
        position = pos;
        value    = val;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_list_op(op, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic random_small_op(input int max_len);
        int                       sel;
        logic [KIND_W-1:0]        op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        sel = $urandom_range(0, 99);
        val = pick_word();
        if (sel < 34)
            op = (list_count >= max_len) ? K_DELETE : K_INSERT;
        else if (sel < 50)
            op = (list_count == 0) ? K_INSERT : K_DELETE;
        else if (sel < 62)
            op = K_GET;
        else if (sel < 74)
            op = K_LOCATE;
        else if (sel < 84)
            op = K_PRED;
        else if (sel < 94)
            op = K_SUCC;
        else if (sel < 97)
            op = $urandom_range(0, 1) ? K_SPARE6 : K_SPARE7;
        else
            op = KIND_W'($urandom_range(0, 7));
        if (sel >= 97)
            pos = POS_W'($urandom_range(0, 511));
        else if (op == K_INSERT)
            pos = pick_position(list_count + 1);
        else if (op == K_DELETE || op == K_GET)
            pos = pick_position(list_count);
        else
            pos = POS_W'($urandom_range(0, 511));
        send_op(op, pos, val, 1'b0, '0);
    endtask

    task automatic fill_and_drain();
        int sel;
        while (list_count < CAPACITY)
            send_op(K_INSERT, POS_W'($urandom_range(1, list_count + 1)), pick_word(), 1'b0,
                    '0);
        repeat (24)
        begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: send_op(K_INSERT, POS_W'($urandom_range(1, list_count + 1)), $urandom,
                           1'b0, '0);
                1: send_op(K_INSERT, POS_W'(CAPACITY + 2), $urandom, 1'b0, '0);
                2: send_op(K_GET, POS_W'($urandom_range(CAPACITY - 1, CAPACITY + 1)), '0,
                           1'b0, '0);
                3: send_op(K_LOCATE, POS_W'($urandom_range(0, 511)), pick_word(), 1'b0, '0);
                4: send_op($urandom_range(0, 1) ? K_PRED : K_SUCC,
                           POS_W'($urandom_range(0, 511)), pick_word(), 1'b0, '0);
                default:
                begin
                    send_op(K_DELETE, POS_W'($urandom_range(1, list_count)), '0, 1'b0, '0);
                    send_op(K_INSERT, POS_W'($urandom_range(1, list_count + 1)), pick_word(),
                            1'b0, '0);
                end
            endcase
        end
        while (list_count > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                send_op(K_LOCATE, '0, pick_word(), 1'b0, '0);
            send_op(K_DELETE, POS_W'($urandom_range(1, list_count)), $urandom, 1'b0, '0);
        end
    endtask

    task automatic check_result();
        list_result_t exp_res;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected transaction status %0d value %0d", $time, status,
                     result_value);
            mismatch_count++;
        end
        else
        begin
            exp_res = pending_results.pop_front();
            if (status !== exp_res.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status);
                mismatch_count++;
            end
            if (result_value !== exp_res.rval)
            begin
                $display("%0t: result_value expected %0d actual %0d", $time, exp_res.rval,
                         result_value);
                mismatch_count++;
            end
            if (found_position !== exp_res.fpos)
            begin
                $display("%0t: found_position expected %0d actual %0d", $time, exp_res.fpos,
                         found_position);
                mismatch_count++;
            end
            if (list_length !== exp_res.len)
            begin
                $display("%0t: list_length expected %0d actual %0d", $time, exp_res.len,
                         list_length);
                mismatch_count++;
            end
            if (is_empty !== exp_res.empty)
            begin
                $display("%0t: is_empty expected %0d actual %0d", $time, exp_res.empty,
                         is_empty);
                mismatch_count++;
            end
        end
        results_taken++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
                check_result();
        end
    end

    initial
    begin
        int stall_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!holdoff_done && results_taken >= 40)
            begin
                stall_len    = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            else if (!steady_phase && $urandom_range(0, 5) == 0)
                stall_len = $urandom_range(1, 4);
            else
                stall_len = 0;
            if (stall_len > 0)
            begin
                out_stall = 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall = 1'b0;
            @(negedge clk);
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        list_result_t typed_res;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = '0;
        position = '0;
        value    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            typed_res.st    = DIRECTED[i].st;
            typed_res.rval  = DIRECTED[i].rval;
            typed_res.fpos  = DIRECTED[i].fpos;
            typed_res.len   = DIRECTED[i].len;
            typed_res.empty = (DIRECTED[i].len == 0);
            send_op(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].val, DIRECTED[i].typed,
                    typed_res);
        end

        repeat (SMALL_ITEMS) random_small_op(12);
        fill_and_drain();

        steady_phase = 1'b1;
        repeat (STEADY_ITEMS) random_small_op(8);
        in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ols_pkg.sv
rtl/ols_cell.sv
rtl/ols_ctrl.sv
rtl/ordered_list_store_top.sv
dv/ordered_list_store_top_tb.sv
